[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gcdisp_pkg.sv]
package gcdisp_pkg;

  // Field and register widths
  localparam int unsigned W         = 16;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned NUM_DENOM = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CNT_W     = $clog2(W + 1);

  localparam int unsigned NUM_SLOTS_DEF = 8;

  // Input commands
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_DISPENSE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_t;

  // Status of a bit-serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[rtl/gcdisp_div.sv]
`include "assert_macros.svh"

module gcdisp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gcdisp_pkg::W-1:0]       dividend,
  input  logic [gcdisp_pkg::W-1:0]       divisor,
  output logic [gcdisp_pkg::W-1:0]       quotient,
  output logic [gcdisp_pkg::W-1:0]       remainder,
  output gcdisp_pkg::unit_stat_t         stat
);

  localparam int unsigned W = gcdisp_pkg::W;

  logic [W-1:0]                   rem;
  logic [W-1:0]                   quo;
  logic [W-1:0]                   dvs;
  logic [gcdisp_pkg::CNT_W-1:0]   cnt;
  logic                           busy;
  logic                           done;
  logic [W:0]                     shifted;
  logic                           fits;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, quo[W-1]};
    fits    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= gcdisp_pkg::CNT_W'(W);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[W-1:0];
        end
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == gcdisp_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

  `ASSERT_CLK(a_div_done_pulse, done |=> !done, "divider done held longer than one cycle")
  `ASSERT_CLK(a_div_done_idle, done |-> !busy, "divider done while still busy")
  `ASSERT_CLK(a_div_rem_below, (busy && !start) |-> (rem < dvs), "partial remainder not below divisor")

endmodule

[rtl/gcdisp_mul.sv]
`include "assert_macros.svh"

module gcdisp_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gcdisp_pkg::W-1:0]       multiplier,
  input  logic [gcdisp_pkg::W-1:0]       multiplicand,
  output logic [gcdisp_pkg::W-1:0]       product,
  output gcdisp_pkg::unit_stat_t         stat
);

  localparam int unsigned W = gcdisp_pkg::W;

  logic [W-1:0]                   acc;
  logic [W-1:0]                   mcand;
  logic [W-1:0]                   mplier;
  logic [gcdisp_pkg::CNT_W-1:0]   cnt;
  logic                           busy;
  logic                           done;

  // Shift-add, one multiplier bit per cycle, product kept modulo 2^W
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= gcdisp_pkg::CNT_W'(W);
        acc    <= '0;
        mcand  <= multiplicand;
        mplier <= multiplier;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[W-2:0], 1'b0};
        mplier <= {1'b0, mplier[W-1:1]};
        cnt    <= cnt - 1'b1;
        if (cnt == gcdisp_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

  `ASSERT_CLK(a_mul_done_pulse, done |=> !done, "multiplier done held longer than one cycle")
  `ASSERT_CLK(a_mul_done_idle, done |-> !busy, "multiplier done while still busy")

endmodule

[rtl/greedy_change_dispenser.sv]
// Load beat: taken while idle, no result beat.
// Dispense beat: per slot, a zero denomination goes straight to the result; else the
// 16-step serial divider runs, and the 16-step serial multiplier too when the stock
// does not cover the quotient and clamps; every result beat then waits for out_ready.
// One item at a time; in_ready only while idle.
// Reset (synchronous, rst high) clears denominations, stock and all control state.
`include "assert_macros.svh"

module greedy_change_dispenser #(
  parameter int unsigned NUM_SLOTS = gcdisp_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [gcdisp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcdisp_pkg::W-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [gcdisp_pkg::SLOT_W-1:0]     slot,
  input  logic [gcdisp_pkg::W-1:0]          value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gcdisp_pkg::SLOT_W-1:0]     out_slot,
  output logic [gcdisp_pkg::W-1:0]          units_given,
  output logic [gcdisp_pkg::W-1:0]          stock_left,
  output logic [gcdisp_pkg::W-1:0]          amount_left,
  output logic                              last
);

  localparam int unsigned W      = gcdisp_pkg::W;
  localparam int unsigned SLOT_W = gcdisp_pkg::SLOT_W;
  localparam int unsigned IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  gcdisp_pkg::state_t     state;
  gcdisp_pkg::state_t     state_next;

  logic [W-1:0]           denom [gcdisp_pkg::NUM_DENOM];
  logic [W-1:0]           stock [NUM_SLOTS];
  logic [W-1:0]           amount;
  logic [SLOT_W-1:0]      cur;
  logic [IDX_W-1:0]       cur_idx;
  logic [W-1:0]           denom_cur;
  logic [W-1:0]           stock_cur;
  logic                   cur_last;
  logic                   load_ok;

  logic                   div_start;
  logic                   mul_start;
  logic [W-1:0]           div_q;
  logic [W-1:0]           div_r;
  logic [W-1:0]           mul_p;
  gcdisp_pkg::unit_stat_t div_stat;
  gcdisp_pkg::unit_stat_t mul_stat;

  // Current slot lookups
  always_comb begin
    cur_idx   = cur[IDX_W-1:0];
    denom_cur = denom[cur];
    stock_cur = stock[cur_idx];
    cur_last  = (cur == SLOT_W'(NUM_SLOTS - 1));
    load_ok   = ({1'b0, slot} < (SLOT_W + 1)'(NUM_SLOTS));
  end

  // Denomination registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gcdisp_pkg::NUM_DENOM; i++) begin
        denom[i] <= '0;
      end
    end else if (cfg_wen && (cfg_index < gcdisp_pkg::CFG_IDX_W'(gcdisp_pkg::NUM_DENOM))) begin
      denom[cfg_index[SLOT_W-1:0]] <= cfg_data;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcdisp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    unique case (state)
      gcdisp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (command == gcdisp_pkg::CMD_DISPENSE)) begin
          state_next = gcdisp_pkg::ST_SLOT;
        end
      end
      gcdisp_pkg::ST_SLOT: begin
        if (denom_cur == '0) begin
          state_next = gcdisp_pkg::ST_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = gcdisp_pkg::ST_DIV;
        end
      end
      gcdisp_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (div_q > stock_cur) begin
            mul_start  = 1'b1;
            state_next = gcdisp_pkg::ST_MUL;
          end else begin
            state_next = gcdisp_pkg::ST_EMIT;
          end
        end
      end
      gcdisp_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          state_next = gcdisp_pkg::ST_EMIT;
        end
      end
      gcdisp_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = cur_last ? gcdisp_pkg::ST_IDLE : gcdisp_pkg::ST_SLOT;
        end
      end
      default: begin
        state_next = gcdisp_pkg::ST_IDLE;
      end
    endcase
  end

  // Slot pointer and stock table
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        stock[i] <= '0;
      end
    end else begin
      if ((state == gcdisp_pkg::ST_IDLE) && in_valid) begin
        if (command == gcdisp_pkg::CMD_DISPENSE) begin
          cur <= '0;
        end else if (load_ok) begin
          stock[slot[IDX_W-1:0]] <= value;
        end
      end
      if ((state == gcdisp_pkg::ST_DIV) && div_stat.done) begin
        if (div_q > stock_cur) begin
          stock[cur_idx] <= '0;
        end else begin
          stock[cur_idx] <= stock_cur - div_q;
        end
      end
      if ((state == gcdisp_pkg::ST_EMIT) && out_ready && !cur_last) begin
        cur <= cur + 1'b1;
      end
    end
  end

  // Unpaid amount and result register
  always_ff @(posedge clk) begin
    if ((state == gcdisp_pkg::ST_IDLE) && in_valid && (command == gcdisp_pkg::CMD_DISPENSE)) begin
      amount <= value;
    end
    if ((state == gcdisp_pkg::ST_SLOT) && (denom_cur == '0)) begin
      units_given <= '0;
      stock_left  <= stock_cur;
      amount_left <= amount;
    end
    if ((state == gcdisp_pkg::ST_DIV) && div_stat.done) begin
      if (div_q > stock_cur) begin
        units_given <= stock_cur;
        stock_left  <= '0;
      end else begin
        units_given <= div_q;
        stock_left  <= stock_cur - div_q;
        amount      <= div_r;
        amount_left <= div_r;
      end
    end
    if ((state == gcdisp_pkg::ST_MUL) && mul_stat.done) begin
      amount      <= amount - mul_p;
      amount_left <= amount - mul_p;
    end
  end

  assign out_slot = cur;
  assign last     = cur_last;

  gcdisp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (amount),
    .divisor   (denom_cur),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (div_stat)
  );

  gcdisp_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplier   (stock_cur),
    .multiplicand (denom_cur),
    .product      (mul_p),
    .stat         (mul_stat)
  );

  `ASSERT_CLK(a_ready_xor_valid, !(in_ready && out_valid), "input and output open together")
  `ASSERT_CLK(a_last_slot, (out_valid && last) |-> (out_slot == SLOT_W'(NUM_SLOTS - 1)), "last flag on wrong slot")
  `ASSERT_CLK(a_back_to_idle, (out_valid && out_ready && last) |=> in_ready, "no return to idle after final beat")
  `ASSERT_CLK(a_units_bound, out_valid |-> (units_given <= (units_given + stock_left)), "units exceed stock")

endmodule

[bench/change_checker.sv]
`timescale 1ns / 100ps

module change_checker #(
  parameter int unsigned NUM_SLOTS = gcdisp_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [gcdisp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcdisp_pkg::W-1:0]          cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              command,
  input  logic [gcdisp_pkg::SLOT_W-1:0]     slot,
  input  logic [gcdisp_pkg::W-1:0]          value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [gcdisp_pkg::SLOT_W-1:0]     out_slot,
  input  logic [gcdisp_pkg::W-1:0]          units_given,
  input  logic [gcdisp_pkg::W-1:0]          stock_left,
  input  logic [gcdisp_pkg::W-1:0]          amount_left,
  input  logic                              last,
  output int                                errors,
  output int                                pending,
  output int                                beats_checked
);

  localparam int unsigned W         = gcdisp_pkg::W;
  localparam int unsigned SLOT_W    = gcdisp_pkg::SLOT_W;
  localparam int unsigned NUM_DENOM = gcdisp_pkg::NUM_DENOM;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [W-1:0]      units;
    logic [W-1:0]      stock;
    logic [W-1:0]      amount;
    logic              last;
  } change_beat_t;

  // Shadow copy of the denomination registers and the coin stock
  logic [W-1:0] denom_value [NUM_DENOM];
  logic [W-1:0] coin_stock  [NUM_DENOM];
  change_beat_t change_due  [$];
  change_beat_t want;

  // Walk the slots greedily, clamp to stock, queue one beat per slot
  function automatic void predict_change(input logic [W-1:0] amount);
    logic [W-1:0]   owed;
    logic [W-1:0]   units;
    logic [2*W-1:0] paid;
    change_beat_t   beat;
    owed = amount;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      units = '0;
      if (denom_value[i] != '0) begin
        units = owed / denom_value[i];
        if (units > coin_stock[i]) units = coin_stock[i];
        paid = units * denom_value[i];
        owed = owed - paid[W-1:0];
        coin_stock[i] = coin_stock[i] - units;
      end
      beat.slot   = i[SLOT_W-1:0];
      beat.units  = units;
      beat.stock  = coin_stock[i];
      beat.amount = owed;
      beat.last   = (i == NUM_SLOTS - 1);
      change_due.push_back(beat);
    end
  endfunction

  function automatic void compare_field(input string field, input logic [W-1:0] exp_val,
                                        input logic [W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch on beat for slot %0d: expected %0d, actual %0d",
               $time, field, want.slot, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DENOM; i++) begin
        denom_value[i] = '0;
        coin_stock[i]  = '0;
      end
      change_due.delete();
    end else begin
      // track register writes; indexes past the table are dropped
      if (cfg_wen && cfg_index < NUM_DENOM) denom_value[cfg_index[SLOT_W-1:0]] = cfg_data;
      // loads refill one slot, dispenses produce a full walk
      if (in_valid && in_ready) begin
        if (command == gcdisp_pkg::CMD_LOAD) begin
          if (slot < NUM_SLOTS) coin_stock[slot] = value;
        end else begin
          predict_change(value);
        end
      end
      // compare each change beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (change_due.size() == 0) begin
          $display("%0t: unexpected change beat for slot %0d: expected none, actual units %0d",
                   $time, out_slot, units_given);
          errors++;
        end else begin
          want = change_due.pop_front();
          compare_field("out_slot", W'(want.slot), W'(out_slot));
          compare_field("units_given", want.units, units_given);
          compare_field("stock_left", want.stock, stock_left);
          compare_field("amount_left", want.amount, amount_left);
          compare_field("last", W'(want.last), W'(last));
          beats_checked++;
        end
      end
    end
    pending = change_due.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int unsigned W           = gcdisp_pkg::W;
  localparam int unsigned SLOT_W      = gcdisp_pkg::SLOT_W;
  localparam int unsigned CFG_IDX_W   = gcdisp_pkg::CFG_IDX_W;
  localparam int unsigned NUM_DENOM   = gcdisp_pkg::NUM_DENOM;
  localparam int unsigned NUM_SLOTS   = gcdisp_pkg::NUM_SLOTS_DEF;
  localparam int          REG_DENOM0  = 0;
  localparam int          REG_IDX_MAX = (1 << CFG_IDX_W) - 1;
  localparam int          NUM_PHASES  = 6;
  localparam int          PHASE_ITEMS = 50;
  localparam int          SETTLE_CYC  = 4;
  localparam int          TAIL_CYC    = 300;
  localparam int          IDLE_LIMIT  = 5000;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic              clk;
  logic              rst;
  logic              cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0]      cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              command;
  logic [SLOT_W-1:0] slot;
  logic [W-1:0]      value;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic [W-1:0]      units_given;
  logic [W-1:0]      stock_left;
  logic [W-1:0]      amount_left;
  logic              last;
  int                errors;
  int                pending;
  int                beats_checked;

  logic [W-1:0] denom_plan [NUM_DENOM];
  int           burst_left;
  int           n_loads;
  int           n_dispenses;
  int           n_settings;
  int           idle_cycles;
  rx_mode_t     ready_mode;
  int unsigned  mode_left;

  greedy_change_dispenser #(.NUM_SLOTS(NUM_SLOTS)) u_top (.*);

  change_checker #(.NUM_SLOTS(NUM_SLOTS)) u_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: hold each stall pattern for a random stretch, then switch
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= rx_mode_t'($urandom_range(3, 0));
        mode_left  <= $urandom_range(150, 20);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(1, 0);
        RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
        default:   out_ready <= ((mode_left % 7) < 4);
      endcase
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d change beats outstanding",
               $time, idle_cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input int idx, input logic [W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Drop valid, wait for all change beats, then let a load finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_denoms();
    for (int i = 0; i < NUM_DENOM; i++) write_reg(REG_DENOM0 + i, denom_plan[i]);
    cfg_wen <= 1'b0;
    n_settings++;
  endtask

  // Present one beat and hold it until accepted
  task automatic send(input logic cmd, input logic [SLOT_W-1:0] s, input logic [W-1:0] v);
    in_valid <= 1'b1;
    command  <= cmd;
    slot     <= s;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (cmd == gcdisp_pkg::CMD_LOAD) n_loads++;
    else n_dispenses++;
  endtask

  // Advance the burst; between bursts drop valid for a random gap
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(4, 0) == 0) ? 30 : $urandom_range(8, 1);
    end
  endtask

  initial begin
    int unsigned top_val;
    int unsigned pick;
    logic [31:0] v;
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    command   <= gcdisp_pkg::CMD_LOAD;
    slot      <= '0;
    value     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all denominations unused after reset: every slot passes the amount on
    send(gcdisp_pkg::CMD_DISPENSE, 3'd0, 16'hFFFF);
    settle();

    // standard coin set; writes past the table must not alias onto it
    denom_plan = '{16'd500, 16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd1};
    load_denoms();
    write_reg(REG_DENOM0 + NUM_DENOM, 16'hFFFF);
    write_reg(REG_IDX_MAX, 16'h1234);
    cfg_wen <= 1'b0;

    send(gcdisp_pkg::CMD_LOAD, 3'd0, 16'd3);
    send(gcdisp_pkg::CMD_LOAD, 3'd1, 16'hFFFF);
    send(gcdisp_pkg::CMD_LOAD, 3'd2, 16'd2);
    send(gcdisp_pkg::CMD_LOAD, 3'd3, 16'd0);
    send(gcdisp_pkg::CMD_LOAD, 3'd4, 16'd5);
    send(gcdisp_pkg::CMD_LOAD, 3'd5, 16'd1);
    send(gcdisp_pkg::CMD_LOAD, 3'd6, 16'd4);
    send(gcdisp_pkg::CMD_LOAD, 3'd7, 16'hFFFF);
    send(gcdisp_pkg::CMD_DISPENSE, 3'd7, 16'd0);
    send(gcdisp_pkg::CMD_DISPENSE, 3'd0, 16'd1888);
    send(gcdisp_pkg::CMD_DISPENSE, 3'd5, 16'hFFFF);
    send(gcdisp_pkg::CMD_DISPENSE, 3'd2, 16'd7);
    // stock runs short: the rest stays unpaid on the last beat
    send(gcdisp_pkg::CMD_LOAD, 3'd6, 16'd0);
    send(gcdisp_pkg::CMD_LOAD, 3'd7, 16'd2);
    send(gcdisp_pkg::CMD_DISPENSE, 3'd1, 16'd9);
    send(gcdisp_pkg::CMD_LOAD, 3'd0, 16'hFFFF);
    send(gcdisp_pkg::CMD_DISPENSE, 3'd4, 16'hFFFF);

    // random phases, each under its own denomination setting
    burst_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      top_val = (ph == 2) ? 65535 : $urandom_range(2000, 1);
      for (int i = 0; i < NUM_DENOM; i++) begin
        denom_plan[i] = top_val[W-1:0];
        top_val = $urandom_range(top_val, 1);
      end
      case (ph)
        1: for (int i = 0; i < NUM_DENOM; i++)
             if ($urandom_range(2, 0) == 0) denom_plan[i] = '0;
        2: begin
          denom_plan[3] = '0;
          denom_plan[7] = 16'd1;
        end
        3: for (int i = 0; i < NUM_DENOM; i++) denom_plan[i] = W'($urandom);
        4: for (int i = 0; i < NUM_DENOM; i++) denom_plan[i] = 16'd1;
        5: denom_plan[7] = 16'd1;
        default: ;
      endcase
      load_denoms();

      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(3, 0);
        if ($urandom_range(99, 0) < 55) begin
          // mostly small refills so the stock runs out often
          v = (pick == 0) ? $urandom : $urandom_range(40, 0);
          send(gcdisp_pkg::CMD_LOAD, SLOT_W'($urandom_range(7, 0)), v[W-1:0]);
        end else begin
          case (pick)
            0:       v = $urandom;
            1:       v = $urandom_range(100, 0);
            default: v = $urandom_range(5000, 0);
          endcase
          send(gcdisp_pkg::CMD_DISPENSE, SLOT_W'($urandom_range(7, 0)), v[W-1:0]);
        end
        pace();
      end
    end

    // drain, then watch for stray beats
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYC) @(posedge clk);

    $display("Ran %0d stock loads and %0d dispenses under %0d denomination settings,",
             n_loads, n_dispenses, n_settings);
    $display("checking %0d change beats with random bursts and receiver stalls.",
             beats_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
